### design/lrutsb_pkg.sv
// ---------------------------------------------------------------------------
// lrutsb_pkg - shared types and constants for the texture slot binder
// Slot geometry, field widths, command codes and inter-module structs.
// ---------------------------------------------------------------------------
package lrutsb_pkg;

  localparam int SLOTS      = 32;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int HANDLE_W   = 32;
  localparam int TARGET_W   = 16;
  localparam int CMD_W      = 2;
  localparam int UNITS_W    = 6;
  localparam int OUT_SLOT_W = 5;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;
  localparam int REGIDX_W   = ADDR_W - 2;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [SLOT_W-1:0]   slot_idx_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [TARGET_W-1:0] target_t;
  typedef logic [UNITS_W-1:0]  units_t;
  typedef logic [REGIDX_W-1:0] reg_idx_t;

  localparam cmd_t CMD_BIND   = 2'd0;
  localparam cmd_t CMD_UNBIND = 2'd1;
  localparam cmd_t CMD_FLUSH  = 2'd2;
  localparam cmd_t CMD_CLEAR  = 2'd3;

  localparam reg_idx_t REG_UNITS   = '0;
  localparam units_t   UNITS_RESET = 6'd32;

  // recency update request
  typedef struct packed {
    logic      en;
    slot_idx_t slot;
  } touch_t;

  // slot store write request
  typedef struct packed {
    logic      en;
    slot_idx_t addr;
    handle_t   handle;
    target_t   target;
  } ram_wr_t;

  // shared compare unit result
  typedef struct packed {
    logic match;
    logic older;
  } cmp_res_t;

endpackage

### design/lrutsb_slot_ram.sv
// ---------------------------------------------------------------------------
// lrutsb_slot_ram - handle and target store
// One write port, one registered read port on the handle array.
// ---------------------------------------------------------------------------
module lrutsb_slot_ram (
  input  logic                 clk,
  input  lrutsb_pkg::ram_wr_t  wr,
  input  logic                 rd_en,
  input  lrutsb_pkg::slot_idx_t rd_addr,
  output lrutsb_pkg::handle_t  rd_handle
);
  import lrutsb_pkg::*;

  handle_t handle_mem [SLOTS];
  target_t target_mem [SLOTS];
  handle_t rd_handle_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      handle_mem[wr.addr] <= wr.handle;
      target_mem[wr.addr] <= wr.target;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_handle_r <= handle_mem[rd_addr];
    end
  end

  assign rd_handle = rd_handle_r;

endmodule

### design/lrutsb_recency.sv
// ---------------------------------------------------------------------------
// lrutsb_recency - per-slot recency rank
// Rank 0 is most recent. A touch moves a slot to rank 0 and ages the
// slots that were ahead of it.
// ---------------------------------------------------------------------------
module lrutsb_recency (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lrutsb_pkg::touch_t    touch,
  input  lrutsb_pkg::slot_idx_t rd_idx,
  output lrutsb_pkg::slot_idx_t rd_rank
);
  import lrutsb_pkg::*;

  slot_idx_t rank_r   [SLOTS];
  slot_idx_t rank_nxt [SLOTS];
  slot_idx_t tgt_rank;

  always_comb begin
    tgt_rank = rank_r[touch.slot];
    for (int s = 0; s < SLOTS; s++) begin
      rank_nxt[s] = rank_r[s];
      if (touch.en) begin
        if (SLOT_W'(s) == touch.slot) begin
          rank_nxt[s] = '0;
        end else if (rank_r[s] < tgt_rank) begin
          rank_nxt[s] = rank_r[s] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < SLOTS; s++) begin
      if (!rst_n) begin
        rank_r[s] <= SLOT_W'(s);
      end else begin
        rank_r[s] <= rank_nxt[s];
      end
    end
  end

  assign rd_rank = rank_r[rd_idx];

endmodule

### design/lrutsb_cmp.sv
// ---------------------------------------------------------------------------
// lrutsb_cmp - shared compare unit
// Handle match against the key and rank test for the LRU candidate.
// ---------------------------------------------------------------------------
module lrutsb_cmp (
  input  lrutsb_pkg::handle_t   rd_handle,
  input  logic                  rd_live,
  input  lrutsb_pkg::handle_t   key,
  input  lrutsb_pkg::slot_idx_t rank,
  input  lrutsb_pkg::slot_idx_t best_rank,
  input  logic                  best_found,
  output lrutsb_pkg::cmp_res_t  res
);
  import lrutsb_pkg::*;

  // empty slots are masked by rd_live; key is never zero here
  assign res.match = rd_live && (rd_handle == key);
  assign res.older = !best_found || (rank > best_rank);

endmodule

### design/lru_texture_slot_binder_top.sv
// ---------------------------------------------------------------------------
// lru_texture_slot_binder_top - LRU texture binding slot cache
// Binds resource handles to a small fully associative set of slots.
// ---------------------------------------------------------------------------
// Usage:
//   Input words (in_cmd, in_handle, in_target) arrive on a valid/stall
//   channel: bind, unbind, flush usage bits, clear all slots. Each word
//   gives exactly one result word on the out_ channel (slot, status, hit,
//   evicted, evicted_handle). units_in_use is written over the APB port
//   at byte address 0 (values above the slot count saturate); the user
//   must write it only while idle, which the block does not enforce.
// Operation:
//   Bind/unbind walk the n active slots via one registered read port
//   and one shared compare unit; a bind stops early on a hit. Flush,
//   clear-all, failed binds and null unbinds do not walk the slots.
//   One word is in flight at a time; in_stall is high while it is worked.
// Reset:
//   Synchronous, active low. All slots empty, usage bits clear, recency
//   rank equals slot number, units_in_use = 32.
// Output stall:
//   The result sits in a holding register; the output register keeps its
//   word while out_stall is high, and the next result waits behind it.
// ---------------------------------------------------------------------------
module lru_texture_slot_binder_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lrutsb_pkg::cmd_t                in_cmd,
  input  logic [lrutsb_pkg::HANDLE_W-1:0] in_handle,
  input  logic [lrutsb_pkg::TARGET_W-1:0] in_target,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lrutsb_pkg::OUT_SLOT_W-1:0] out_slot,
  output logic                              out_status,
  output logic                              out_hit,
  output logic                              out_evicted,
  output logic [lrutsb_pkg::HANDLE_W-1:0]   out_evicted_handle,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lrutsb_pkg::ADDR_W-1:0]   paddr,
  input  logic [lrutsb_pkg::DATA_W-1:0]   pwdata,
  output logic [lrutsb_pkg::DATA_W-1:0]   prdata,
  output logic                            pready
);
  import lrutsb_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  // ---- configuration ----
  units_t units_r, units_nxt;
  logic   cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_UNITS);
  assign prdata = (paddr[ADDR_W-1:2] == REG_UNITS) ? DATA_W'(units_r) : '0;

  always_comb begin
    units_nxt = units_r;
    if (cfg_wr) begin
      units_nxt = pwdata[UNITS_W-1:0];
    end
  end

  // ---- control state ----
  logic [1:0]       state_r, state_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;   // slot holds a handle
  logic [SLOTS-1:0] used_r, used_nxt;     // usage bits
  logic             out_valid_r, out_valid_nxt;
  logic             rd_vld_r, rd_vld_nxt;

  // ---- working registers ----
  cmd_t              cmd_r, cmd_nxt;
  handle_t           key_r, key_nxt;
  target_t           tgt_r, tgt_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  slot_idx_t         rd_idx_r, rd_idx_nxt;
  logic              rd_live_r, rd_live_nxt;
  logic              hit_r, hit_nxt;
  slot_idx_t         hit_idx_r, hit_idx_nxt;
  logic              free_found_r, free_found_nxt;
  slot_idx_t         free_idx_r, free_idx_nxt;
  logic              lru_found_r, lru_found_nxt;
  slot_idx_t         lru_idx_r, lru_idx_nxt;
  slot_idx_t         lru_rank_r, lru_rank_nxt;
  handle_t           lru_handle_r, lru_handle_nxt;

  // result holding register
  slot_idx_t res_slot_r, res_slot_nxt;
  logic      res_status_r, res_status_nxt;
  logic      res_hit_r, res_hit_nxt;
  logic      res_ev_r, res_ev_nxt;
  handle_t   res_evh_r, res_evh_nxt;

  // output register
  logic [OUT_SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic                  out_status_r, out_status_nxt;
  logic                  out_hit_r, out_hit_nxt;
  logic                  out_ev_r, out_ev_nxt;
  handle_t               out_evh_r, out_evh_nxt;

  // ---- submodules ----
  ram_wr_t   ram_wr;
  logic      ram_rd_en;
  slot_idx_t ram_rd_addr;
  handle_t   ram_rd_handle;
  touch_t    touch;
  slot_idx_t rd_rank;
  cmp_res_t  cmp;

  lrutsb_slot_ram u_ram (
    .clk       (clk),
    .wr        (ram_wr),
    .rd_en     (ram_rd_en),
    .rd_addr   (ram_rd_addr),
    .rd_handle (ram_rd_handle)
  );

  lrutsb_recency u_recency (
    .clk     (clk),
    .rst_n   (rst_n),
    .touch   (touch),
    .rd_idx  (rd_idx_r),
    .rd_rank (rd_rank)
  );

  lrutsb_cmp u_cmp (
    .rd_handle  (ram_rd_handle),
    .rd_live    (rd_live_r),
    .key        (key_r),
    .rank       (rd_rank),
    .best_rank  (lru_rank_r),
    .best_found (lru_found_r),
    .res        (cmp)
  );

  // ---- handshakes ----
  logic             in_acc;
  logic             issue;
  logic             out_free;
  logic [CNT_W-1:0] n_acc;
  slot_idx_t        pick;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign issue    = (iss_r < n_r);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (int'(units_r) > SLOTS) begin
      n_acc = CNT_W'(SLOTS);
    end else begin
      n_acc = CNT_W'(units_r);
    end
  end

  // miss victim: lowest slot with a clear usage bit, else least recent
  assign pick = free_found_r ? free_idx_r : lru_idx_r;

  // ---- sequencer ----
  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    used_nxt       = used_r;
    rd_vld_nxt     = 1'b0;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    tgt_nxt        = tgt_r;
    n_nxt          = n_r;
    iss_nxt        = iss_r;
    rd_idx_nxt     = rd_idx_r;
    rd_live_nxt    = rd_live_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    lru_found_nxt  = lru_found_r;
    lru_idx_nxt    = lru_idx_r;
    lru_rank_nxt   = lru_rank_r;
    lru_handle_nxt = lru_handle_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;
    res_hit_nxt    = res_hit_r;
    res_ev_nxt     = res_ev_r;
    res_evh_nxt    = res_evh_r;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = iss_r[SLOT_W-1:0];
    ram_wr         = '0;
    ram_wr.addr    = pick;
    ram_wr.handle  = key_r;
    ram_wr.target  = tgt_r;
    touch          = '0;
    touch.slot     = pick;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt        = in_cmd;
          key_nxt        = in_handle;
          tgt_nxt        = in_target;
          n_nxt          = n_acc;
          iss_nxt        = '0;
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          lru_found_nxt  = 1'b0;
          res_slot_nxt   = '0;
          res_status_nxt = 1'b0;
          res_hit_nxt    = 1'b0;
          res_ev_nxt     = 1'b0;
          res_evh_nxt    = '0;
          state_nxt      = ST_RESULT;
          case (in_cmd)
            CMD_BIND: begin
              if (in_handle == '0 || n_acc == '0) begin
                res_status_nxt = 1'b1;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            CMD_UNBIND: begin
              if (in_handle != '0 && n_acc != '0) begin
                state_nxt = ST_SCAN;
              end
            end
            CMD_FLUSH: begin
              used_nxt = '0;
            end
            CMD_CLEAR: begin
              valid_nxt = '0;
              used_nxt  = '0;
            end
            default: begin
              state_nxt = ST_RESULT;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // read pipeline: issue slot iss_r, evaluate slot rd_idx_r
        if (issue) begin
          ram_rd_en   = 1'b1;
          rd_vld_nxt  = 1'b1;
          rd_idx_nxt  = iss_r[SLOT_W-1:0];
          rd_live_nxt = valid_r[iss_r[SLOT_W-1:0]];
          iss_nxt     = iss_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (cmd_r == CMD_UNBIND) begin
            if (cmp.match) begin
              valid_nxt[rd_idx_r] = 1'b0;
              used_nxt[rd_idx_r]  = 1'b0;
            end
          end else if (cmp.match) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = rd_idx_r;
            rd_vld_nxt  = 1'b0;
            state_nxt   = ST_COMMIT;
          end else begin
            if (!free_found_r && !used_r[rd_idx_r]) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = rd_idx_r;
            end
            if (cmp.older) begin
              lru_found_nxt  = 1'b1;
              lru_idx_nxt    = rd_idx_r;
              lru_rank_nxt   = rd_rank;
              lru_handle_nxt = rd_live_r ? ram_rd_handle : '0;
            end
          end
        end
        if (!issue && !rd_vld_r) begin
          state_nxt = (cmd_r == CMD_UNBIND) ? ST_RESULT : ST_COMMIT;
        end
      end

      ST_COMMIT: begin
        state_nxt = ST_RESULT;
        if (hit_r) begin
          touch.en              = 1'b1;
          touch.slot            = hit_idx_r;
          used_nxt[hit_idx_r]   = 1'b1;
          res_slot_nxt          = hit_idx_r;
          res_hit_nxt           = 1'b1;
        end else begin
          ram_wr.en        = 1'b1;
          touch.en         = 1'b1;
          valid_nxt[pick]  = 1'b1;
          used_nxt[pick]   = 1'b1;
          res_slot_nxt     = pick;
          if (!free_found_r) begin
            res_ev_nxt  = 1'b1;
            res_evh_nxt = lru_handle_r;
          end
        end
      end

      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---- output register ----
  logic load_out;

  assign load_out = (state_r == ST_RESULT) && out_free;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    out_hit_nxt    = out_hit_r;
    out_ev_nxt     = out_ev_r;
    out_evh_nxt    = out_evh_r;
    if (load_out) begin
      out_valid_nxt  = 1'b1;
      out_slot_nxt   = OUT_SLOT_W'(res_slot_r);
      out_status_nxt = res_status_r;
      out_hit_nxt    = res_hit_r;
      out_ev_nxt     = res_ev_r;
      out_evh_nxt    = res_evh_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_slot           = out_slot_r;
  assign out_status         = out_status_r;
  assign out_hit            = out_hit_r;
  assign out_evicted        = out_ev_r;
  assign out_evicted_handle = out_evh_r;

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      used_r      <= '0;
      units_r     <= UNITS_RESET;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      used_r      <= used_nxt;
      units_r     <= units_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    tgt_r        <= tgt_nxt;
    n_r          <= n_nxt;
    iss_r        <= iss_nxt;
    rd_idx_r     <= rd_idx_nxt;
    rd_live_r    <= rd_live_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    lru_found_r  <= lru_found_nxt;
    lru_idx_r    <= lru_idx_nxt;
    lru_rank_r   <= lru_rank_nxt;
    lru_handle_r <= lru_handle_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    res_hit_r    <= res_hit_nxt;
    res_ev_r     <= res_ev_nxt;
    res_evh_r    <= res_evh_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_hit_r    <= out_hit_nxt;
    out_ev_r     <= out_ev_nxt;
    out_evh_r    <= out_evh_nxt;
  end

endmodule

### sim/lru_texture_slot_binder_top_test.sv
// ---------------------------------------------------------------------------
// lru_texture_slot_binder_top_test - self-checking bench for the slot binder
// Drives bind, unbind, flush and clear-all words under several slot counts,
// mirrors the slot store and recency order, and checks every result word.
// ---------------------------------------------------------------------------
module lru_texture_slot_binder_top_test;
  import lrutsb_pkg::*;

  localparam int LONG_HOLD  = 300;   // long receiver hold-off, in cycles
  localparam int IDLE_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int TAIL_WAIT  = 40;    // wait after the last drain, in cycles

  // one input word as offered on the in_ channel
  typedef struct packed {
    cmd_t    cmd;
    handle_t handle;
    target_t target;
  } request_t;

  // one result word as seen on the out_ channel
  typedef struct packed {
    logic [OUT_SLOT_W-1:0] slot;
    logic                  status;
    logic                  hit;
    logic                  evicted;
    handle_t               ev_handle;
  } binding_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_stall;
  cmd_t      in_cmd = CMD_BIND;
  handle_t   in_handle = '0;
  target_t   in_target = '0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OUT_SLOT_W-1:0] out_slot;
  logic                  out_status;
  logic                  out_hit;
  logic                  out_evicted;
  handle_t               out_evicted_handle;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lru_texture_slot_binder_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_handle          (in_handle),
    .in_target          (in_target),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_slot           (out_slot),
    .out_status         (out_status),
    .out_hit            (out_hit),
    .out_evicted        (out_evicted),
    .out_evicted_handle (out_evicted_handle),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // 12-unit period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Mirror of the binder: slot store, usage bits, recency list, slot count.
  // recency_list[0] is the most recent slot, the last entry the least recent.
  // -------------------------------------------------------------------------
  handle_t          bound_handle [SLOTS];
  target_t          bound_target [SLOTS];
  logic [SLOTS-1:0] usage_bits;
  int               recency_list [SLOTS];
  units_t           units_mirror;

  request_t pending_words [$];     // words waiting for the driver
  binding_t awaited_results [$];   // predicted results, oldest first
  handle_t  handle_pool [64];

  int  fault_count = 0;
  bit  quiet = 1'b0;       // no gaps and no stalls while set
  bit  hold_req = 1'b0;    // asks the receiver for its long hold-off
  bit  hold_done = 1'b0;
  bit  word_taken = 1'b0;  // input word accepted at the last rising edge
  int  gap_left = 0;
  int  stall_run = 0;

  function automatic void clear_mirror();
    int i;
    for (i = 0; i < SLOTS; i++) begin
      bound_handle[i] = '0;
      bound_target[i] = '0;
      recency_list[i] = i;
    end
    usage_bits = '0;
    units_mirror = UNITS_RESET;
  endfunction

  // pull slot s to the front of the recency list, the rest slide back
  function automatic void move_to_front(int s);
    int p;
    p = 0;
    while (p < SLOTS && recency_list[p] != s) p++;
    if (p < SLOTS) begin
      for (; p > 0; p--) recency_list[p] = recency_list[p-1];
      recency_list[0] = s;
    end
  endfunction

  // apply one word to the mirror and return the result it should give
  function automatic binding_t work_out_binding(cmd_t c, handle_t h, target_t t);
    binding_t r;
    int       n, i, pick;
    bit       found;
    r = '0;
    found = 1'b0;
    pick = 0;
    n = (units_mirror > SLOTS) ? SLOTS : int'(units_mirror);
    case (c)
      CMD_UNBIND: begin
        // only active slots are searched; handle 0 matches nothing
        if (h != '0)
          for (i = 0; i < n; i++)
            if (bound_handle[i] == h) begin
              bound_handle[i] = '0;
              bound_target[i] = '0;
              usage_bits[i] = 1'b0;
            end
      end
      CMD_FLUSH: usage_bits = '0;
      CMD_CLEAR: begin
        // every slot, active or not; recency order is kept
        for (i = 0; i < SLOTS; i++) begin
          bound_handle[i] = '0;
          bound_target[i] = '0;
        end
        usage_bits = '0;
      end
      default: begin
        if (h == '0 || n == 0) begin
          r.status = 1'b1;
        end else begin
          for (i = 0; i < n; i++)
            if (!found && bound_handle[i] == h) begin
              found = 1'b1;
              pick = i;
            end
          if (found) begin
            // hit: stored target stays as it was
            move_to_front(pick);
            usage_bits[pick] = 1'b1;
            r.slot = OUT_SLOT_W'(pick);
            r.hit = 1'b1;
          end else begin
            // lowest active slot with usage clear, even if it holds a handle
            for (i = 0; i < n; i++)
              if (!found && !usage_bits[i]) begin
                found = 1'b1;
                pick = i;
              end
            if (!found) begin
              // all in use: least recent active slot goes
              for (i = SLOTS - 1; i >= 0; i--)
                if (!found && recency_list[i] < n) begin
                  found = 1'b1;
                  pick = recency_list[i];
                end
              if (found) begin
                r.evicted = 1'b1;
                r.ev_handle = bound_handle[pick];
              end
            end
            if (found) begin
              bound_handle[pick] = h;
              bound_target[pick] = t;
              move_to_front(pick);
              usage_bits[pick] = 1'b1;
              r.slot = OUT_SLOT_W'(pick);
            end else begin
              r.status = 1'b1;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  // mostly short idles, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic void queue_word(cmd_t c, handle_t h, target_t t);
    request_t w;
    w.cmd = c;
    w.handle = h;
    w.target = t;
    pending_words.push_back(w);
  endfunction

  // random word; handles mostly from the first span entries of the pool so
  // that hits, fills and evictions all come up at the current slot count
  function automatic void queue_random_word(int span);
    int      r;
    cmd_t    c;
    handle_t h;
    r = $urandom_range(0, 99);
    if (r < 74) c = CMD_BIND;
    else if (r < 88) c = CMD_UNBIND;
    else if (r < 96) c = CMD_FLUSH;
    else c = CMD_CLEAR;
    r = $urandom_range(0, 99);
    if (r < 6) h = '0;
    else if (r < 14) h = $urandom;
    else h = handle_pool[$urandom_range(0, span - 1)];
    queue_word(c, h, target_t'($urandom));
  endfunction

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fault_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // -------------------------------------------------------------------------
  // Driver: offers the next queued word at the falling edge, keeps it steady
  // until taken, then leaves an occasional gap before the next one.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin : word_driver
    request_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        in_cmd    <= w.cmd;
        in_handle <= w.handle;
        in_target <= w.target;
        in_valid  <= 1'b1;
        gap_left = (quiet || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random short and long stalls, plus one long hold-off on
  // request, counted here so the sender keeps pushing into a full block.
  always @(negedge clk) begin : result_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        stall_run = LONG_HOLD;
      end else if (stall_run > 0) begin
        stall_run = stall_run - 1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_run = pick_gap();
      end
      out_stall <= (stall_run > 0);
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: at each rising edge check a taken result word against the
  // oldest prediction, then predict for a taken input word. The watchdog
  // counts edges with no handshake of any kind.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    binding_t seen, want;
    int       idle_cycles;
    if (!rst_n) begin
      word_taken <= 1'b0;
      idle_cycles = 0;
    end else begin
      word_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        seen = {out_slot, out_status, out_hit, out_evicted, out_evicted_handle};
        if (awaited_results.size() == 0) begin
          fault_count++;
          $display("%0t: result word with none expected, got %h", $time, seen);
        end else begin
          want = awaited_results.pop_front();
          report_field("slot", 32'(want.slot), 32'(seen.slot));
          report_field("status", 32'(want.status), 32'(seen.status));
          report_field("hit", 32'(want.hit), 32'(seen.hit));
          report_field("evicted", 32'(want.evicted), 32'(seen.evicted));
          report_field("evicted_handle", want.ev_handle, seen.ev_handle);
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(work_out_binding(in_cmd, in_handle, in_target));

      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (psel && penable && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("lru_texture_slot_binder_top test failed");
        $finish;
      end
    end
  end

  // register write over APB: setup, access, wait for pready
  task automatic write_units(units_t v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_UNITS, 2'b00};
    pwdata  <= DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    units_mirror = v;
  endtask

  // sender holds back until every word is taken and every result is in
  task automatic drain();
    while (pending_words.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  initial begin : stimulus
    int     i, p;
    units_t plan [11];
    clear_mirror();
    handle_pool[0] = 32'hFFFF_FFFF;
    handle_pool[1] = 32'h8000_0000;
    for (i = 2; i < 64; i++) begin
      do handle_pool[i] = $urandom; while (handle_pool[i] == '0);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed part, 32 slots active after reset ----
    queue_word(CMD_BIND, 32'h0, 16'h1234);                // null handle fails
    queue_word(CMD_BIND, 32'hFFFF_FFFF, 16'hFFFF);        // miss into slot 0
    queue_word(CMD_BIND, 32'h1, 16'h0000);                // miss into slot 1
    queue_word(CMD_BIND, 32'hFFFF_FFFF, 16'h0000);        // hit, target kept
    queue_word(CMD_UNBIND, 32'h0, 16'h0);                 // unbind null: no effect
    queue_word(CMD_UNBIND, 32'h5555_AAAA, 16'hFFFF);      // absent handle
    queue_word(CMD_UNBIND, 32'h1, 16'h0);                 // empties slot 1
    queue_word(CMD_FLUSH, 32'hDEAD_BEEF, 16'hA5A5);
    queue_word(CMD_BIND, 32'hAAAA_5555, 16'h8001);        // overwrite flushed slot 0
    queue_word(CMD_BIND, 32'hFFFF_FFFF, 16'h7FFE);        // gone, so a miss again
    queue_word(CMD_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
    queue_word(CMD_BIND, 32'h8000_0000, 16'h7FFF);
    queue_word(CMD_FLUSH, 32'h0, 16'h0);
    drain();

    // two slots: fill, evict the least recent, hit moves recency
    write_units(6'd2);
    queue_word(CMD_BIND, 32'd10, 16'h0010);
    queue_word(CMD_BIND, 32'd20, 16'h0020);
    queue_word(CMD_BIND, 32'd10, 16'h0011);
    queue_word(CMD_BIND, 32'd30, 16'h0030);
    drain();

    // no slots active: every bind fails
    write_units(6'd0);
    queue_word(CMD_BIND, 32'd5, 16'h0005);
    queue_word(CMD_UNBIND, 32'd10, 16'h0);
    queue_word(CMD_BIND, 32'h0, 16'h0);
    queue_word(CMD_CLEAR, 32'h0, 16'h0);
    drain();

    // top of the register range saturates to the slot count
    write_units(6'd63);
    queue_word(CMD_BIND, 32'hFFFF_FFFF, 16'h1111);
    queue_word(CMD_BIND, 32'hFFFF_FFFF, 16'h2222);
    drain();

    // a single slot: each new handle evicts the last
    write_units(6'd1);
    queue_word(CMD_BIND, 32'd7, 16'h0007);
    queue_word(CMD_BIND, 32'd8, 16'h0008);
    drain();

    // ---- random part, one phase per slot count ----
    plan = '{6'd32, 6'd4, 6'd1, 6'd0, 6'd63, 6'd8, 6'd33, 6'd2, 6'd17,
             units_t'($urandom_range(0, 63)), units_t'($urandom_range(0, 63))};
    for (p = 0; p < 11; p++) begin
      write_units(plan[p]);
      quiet = (p == 0);      // one stretch with no idling at all
      hold_req = (p == 1);   // receiver sits out a long spell here
      for (i = 0; i < ((plan[p] == 0) ? 40 : 130); i++)
        queue_random_word((plan[p] > 40) ? 64 : int'(plan[p]) + int'(plan[p]) / 2 + 2);
      drain();
    end

    repeat (TAIL_WAIT) @(posedge clk);
    if (fault_count == 0 && awaited_results.size() == 0)
      $display("lru_texture_slot_binder_top test passed");
    else
      $display("lru_texture_slot_binder_top test failed");
    $finish;
  end

endmodule

### sim.f
design/lrutsb_pkg.sv
design/lrutsb_slot_ram.sv
design/lrutsb_recency.sv
design/lrutsb_cmp.sv
design/lru_texture_slot_binder_top.sv
sim/lru_texture_slot_binder_top_test.sv
